>>> sv/lmps_pkg.sv
// ============================================================================
// lmps_pkg
// Shared types and constants for the LED matrix PWM scanner.
// ============================================================================
package lmps_pkg;

    localparam int ROWS_DEF       = 8;
    localparam int COLS_DEF       = 8;
    localparam int NUM_LEDS_DEF   = 64;
    localparam int SLOT_TICKS_DEF = 128;

    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 8;
    localparam int VALUE_W     = 8;
    localparam int LINES_W     = 8;
    localparam int POS_W       = 6;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int TICK_W      = 7;
    localparam int BRIGHT_DEPTH = 64;
    localparam int CURVE_DEPTH  = 256;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_LED   = 2'd0,
        OP_WRITE_ALL   = 2'd1,
        OP_WRITE_CURVE = 2'd2,
        OP_TICK        = 2'd3
    } opcode_t;

endpackage

>>> sv/led_matrix_pwm_scanner_core.sv
// ============================================================================
// led_matrix_pwm_scanner_core
// Multiplexed LED matrix PWM scanner: brightness and lightness curve stores,
// row/column scan and one line-level item per input item.
// ============================================================================
// Each item passes the brightness read, the curve read and the emit state
// in turn; a write-all item first sweeps every LED of the store. The two
// reads are dependent, brightness store and then curve memory, and no new
// item is taken until the result of the last one has been emitted.
// Reset: aresetn is synchronous, active low. It clears the scan position, then
// a pass writes zero to both memories while s_tready stays low.
module led_matrix_pwm_scanner_core #(
    parameter int ROWS       = lmps_pkg::ROWS_DEF,
    parameter int COLS       = lmps_pkg::COLS_DEF,
    parameter int NUM_LEDS   = lmps_pkg::NUM_LEDS_DEF,
    parameter int SLOT_TICKS = lmps_pkg::SLOT_TICKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input item: s_tdata = {value, index}, index in the lowest bits.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lmps_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser = opcode
    input  logic [lmps_pkg::OPCODE_W-1:0]   s_tuser,
    // Result item: m_tdata = {2'b0, led_position, col_lines, row_lines},
    // row_lines in the lowest bits. m_tlast = frame_end.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lmps_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    import lmps_pkg::*;

    localparam int BADDR_W = $clog2(BRIGHT_DEPTH);
    localparam int CADDR_W = $clog2(CURVE_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE_ALL,
        ST_RD_BRIGHT,
        ST_RD_CURVE,
        ST_EMIT
    } state_t;

    state_t state_reg;

    opcode_t              op_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [BADDR_W-1:0]   sweep_reg;
    logic [CADDR_W-1:0]   clear_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic [POS_W-1:0]     pos_reg;

    logic                 m_tvalid_reg;
    logic [LINES_W-1:0]   row_lines_reg;
    logic [LINES_W-1:0]   col_lines_reg;
    logic [POS_W-1:0]     led_pos_reg;
    logic                 frame_end_reg;

    logic [INDEX_W-1:0]   in_index;
    logic [VALUE_W-1:0]   in_value;
    opcode_t              in_op;
    logic                 accept;

    logic                 b_we;
    logic [BADDR_W-1:0]   b_waddr;
    logic [VALUE_W-1:0]   b_wdata;
    logic                 b_re;
    logic [VALUE_W-1:0]   b_rdata;
    logic                 c_we;
    logic [CADDR_W-1:0]   c_waddr;
    logic [VALUE_W-1:0]   c_wdata;
    logic                 c_re;
    logic [CADDR_W-1:0]   c_raddr;
    logic [VALUE_W-1:0]   c_rdata;

    logic [TICK_W-1:0]    duty;
    logic                 out_free;
    logic                 emit_fire;
    logic                 tick_wrap;
    logic                 last_led;
    logic                 sweep_last;
    logic                 clear_last;
    logic                 led_in_range;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W +: VALUE_W];
    assign in_op    = opcode_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign led_in_range = ({1'b0, in_index} < 9'(NUM_LEDS));
    assign sweep_last   = (sweep_reg == BADDR_W'(NUM_LEDS - 1));
    assign clear_last   = (clear_reg == CADDR_W'(CURVE_DEPTH - 1));

    // In-range single-LED writes and curve writes go straight in on the accepting
    // edge; the write-all sweep uses the single-LED write port afterwards.
    always_comb begin
        b_we    = 1'b0;
        b_waddr = in_index[BADDR_W-1:0];
        b_wdata = in_value;
        if (state_reg == ST_CLEAR) begin
            b_we    = (clear_reg < CADDR_W'(BRIGHT_DEPTH));
            b_waddr = clear_reg[BADDR_W-1:0];
            b_wdata = '0;
        end else if (accept && in_op == OP_WRITE_LED && led_in_range) begin
            b_we = 1'b1;
        end else if (state_reg == ST_WRITE_ALL) begin
            b_we    = 1'b1;
            b_waddr = sweep_reg;
            b_wdata = value_reg;
        end
    end

    always_comb begin
        c_we    = accept && (in_op == OP_WRITE_CURVE);
        c_waddr = in_index;
        c_wdata = in_value;
        if (state_reg == ST_CLEAR) begin
            c_we    = 1'b1;
            c_waddr = clear_reg;
            c_wdata = '0;
        end
    end

    assign b_re = (state_reg == ST_RD_BRIGHT);
    assign c_re = (state_reg == ST_RD_CURVE);

    assign c_raddr = b_rdata;
    assign duty    = c_rdata[VALUE_W-1:1];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign tick_wrap = ({1'b0, tick_reg} + 8'd1) >= 8'(SLOT_TICKS);
    assign last_led  = (({1'b0, pos_reg} + 7'd1) >= 7'(NUM_LEDS)) ||
                       ((({1'b0, col_reg} + 4'd1) >= 4'(COLS)) &&
                        (({1'b0, row_reg} + 4'd1) >= 4'(ROWS)));

    lmps_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (BRIGHT_DEPTH)
    ) u_bright_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (pos_reg),
        .rdata (b_rdata)
    );

    lmps_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CURVE_DEPTH)
    ) u_curve_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            sweep_reg    <= '0;
            clear_reg    <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            tick_reg     <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !emit_fire) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clear_reg <= clear_reg + CADDR_W'(1);
                    if (clear_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= in_op;
                        value_reg <= in_value;
                        sweep_reg <= '0;
                        if (in_op == OP_WRITE_ALL) begin
                            state_reg <= ST_WRITE_ALL;
                        end else begin
                            state_reg <= ST_RD_BRIGHT;
                        end
                    end
                end
                ST_WRITE_ALL: begin
                    sweep_reg <= sweep_reg + BADDR_W'(1);
                    if (sweep_last) begin
                        state_reg <= ST_RD_BRIGHT;
                    end
                end
                ST_RD_BRIGHT: begin
                    state_reg <= ST_RD_CURVE;
                end
                ST_RD_CURVE: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        row_lines_reg <= ~(LINES_W'(1) << row_reg);
                        col_lines_reg <= (tick_reg < duty) ? (LINES_W'(1) << col_reg) : '0;
                        led_pos_reg   <= pos_reg;
                        frame_end_reg <= (op_reg == OP_TICK) && tick_wrap && last_led;
                        state_reg     <= ST_IDLE;
                        if (op_reg == OP_TICK) begin
                            if (!tick_wrap) begin
                                tick_reg <= tick_reg + TICK_W'(1);
                            end else begin
                                tick_reg <= '0;
                                if (last_led) begin
                                    pos_reg <= '0;
                                    row_reg <= '0;
                                    col_reg <= '0;
                                end else begin
                                    pos_reg <= pos_reg + POS_W'(1);
                                    if (({1'b0, col_reg} + 4'd1) < 4'(COLS)) begin
                                        col_reg <= col_reg + COL_W'(1);
                                    end else begin
                                        col_reg <= '0;
                                        row_reg <= row_reg + ROW_W'(1);
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, led_pos_reg, col_lines_reg, row_lines_reg};
    assign m_tlast  = frame_end_reg;

endmodule

>>> sv/lmps_ram.sv
// ============================================================================
// lmps_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module lmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// LED matrix PWM scanner testbench
// The bench drives opcode items into the scanner and checks every line-level
// item it returns against an in-bench model of the stores and the scan. It
// runs a short directed table, then a random mix. Both sides insert random
// gaps.
// ============================================================================
module testbench;
    import lmps_pkg::*;

    localparam int ROWS        = ROWS_DEF;
    localparam int COLS        = COLS_DEF;
    localparam int NUM_LEDS    = NUM_LEDS_DEF;
    localparam int SLOT_TICKS  = SLOT_TICKS_DEF;
    localparam int RANDOM_ITEMS = 1932;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_DIRECTED  = 18;

    typedef struct packed {
        logic [LINES_W-1:0] rows;
        logic [LINES_W-1:0] cols;
        logic [POS_W-1:0]   pos;
        logic               last;
    } scan_line_t;

    typedef struct packed {
        opcode_t            op;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        logic               typed;
        scan_line_t         want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata fields from bit 0: index, value.
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // s_tuser fields from bit 0: opcode.
    logic [OPCODE_W-1:0]    s_tuser = OP_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata fields from bit 0: row_lines, col_lines, led_position, zero pad.
    logic [M_TDATA_W-1:0]   m_tdata;
    // m_tlast carries frame_end.
    logic                   m_tlast;

    // Typed expectation that travels alongside the item on the input side.
    logic                   cur_typed = 1'b0;
    scan_line_t             cur_want = '0;

    // Model state of the scanner.
    logic [VALUE_W-1:0] led_level [BRIGHT_DEPTH] = '{default: '0};
    logic [VALUE_W-1:0] gamma_lut [CURVE_DEPTH] = '{default: '0};
    logic [ROW_W-1:0]   scan_r = '0;
    logic [COL_W-1:0]   scan_c = '0;
    logic [TICK_W-1:0]  pwm_tick = '0;
    logic [POS_W-1:0]   slot_pos = '0;

    scan_line_t expected_lines [$];

    int fail_count = 0;
    int mismatch_count = 0;
    int checked_count = 0;
    int frame_count = 0;
    int tick_items = 0;
    int write_items = 0;
    int idle_cycles = 0;
    int src_calm = 0;
    int sink_calm = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_TICK,        8'd0,   8'd0,   1'b1, '{8'hFE, 8'h00, 6'd0, 1'b0}},
        '{OP_WRITE_CURVE, 8'd255, 8'd255, 1'b1, '{8'hFE, 8'h00, 6'd0, 1'b0}},
        '{OP_WRITE_LED,   8'd0,   8'd255, 1'b0, '0},
        '{OP_WRITE_LED,   8'd63,  8'd255, 1'b0, '0},
        '{OP_WRITE_LED,   8'd64,  8'd0,   1'b0, '0},
        '{OP_WRITE_LED,   8'd255, 8'd0,   1'b0, '0},
        '{OP_TICK,        8'd255, 8'd255, 1'b0, '0},
        '{OP_WRITE_CURVE, 8'd0,   8'd1,   1'b0, '0},
        '{OP_WRITE_ALL,   8'd0,   8'd0,   1'b0, '0},
        '{OP_TICK,        8'd0,   8'd0,   1'b0, '0},
        '{OP_WRITE_CURVE, 8'd0,   8'd255, 1'b0, '0},
        '{OP_TICK,        8'd170, 8'd85,  1'b0, '0},
        '{OP_WRITE_CURVE, 8'd128, 8'd2,   1'b0, '0},
        '{OP_WRITE_ALL,   8'd85,  8'd128, 1'b0, '0},
        '{OP_TICK,        8'd0,   8'd0,   1'b0, '0},
        '{OP_WRITE_CURVE, 8'd128, 8'd0,   1'b0, '0},
        '{OP_WRITE_ALL,   8'd170, 8'd255, 1'b0, '0},
        '{OP_TICK,        8'd85,  8'd170, 1'b0, '0}
    };

    led_matrix_pwm_scanner_core #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .NUM_LEDS   (NUM_LEDS),
        .SLOT_TICKS (SLOT_TICKS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Applies one item to the model stores and returns the lines it shows.
    function automatic scan_line_t predict_lines(opcode_t op, logic [INDEX_W-1:0] idx,
                                                 logic [VALUE_W-1:0] val);
        scan_line_t res;
        logic [VALUE_W-1:0] duty;
        logic last_slot;
        case (op)
            OP_WRITE_LED: begin
                if (int'(idx) < NUM_LEDS)
                    led_level[idx[POS_W-1:0]] = val;
            end
            OP_WRITE_ALL: begin
                for (int i = 0; i < NUM_LEDS; i++)
                    led_level[i] = val;
            end
            OP_WRITE_CURVE: begin
                gamma_lut[idx] = val;
            end
            default: ;
        endcase
        duty = gamma_lut[led_level[slot_pos]] >> 1;
        res.rows = ~(8'd1 << scan_r);
        res.cols = (int'(pwm_tick) < int'(duty)) ? (8'd1 << scan_c) : 8'd0;
        res.pos  = slot_pos;
        res.last = 1'b0;
        // The scan wraps after the last LED or after the last column of the last row, whichever comes first.
        last_slot = (int'(slot_pos) + 1 >= NUM_LEDS) ||
                    (int'(scan_c) + 1 >= COLS && int'(scan_r) + 1 >= ROWS);
        if (op == OP_TICK) begin
            res.last = (int'(pwm_tick) + 1 >= SLOT_TICKS) && last_slot;
            if (int'(pwm_tick) + 1 < SLOT_TICKS) begin
                pwm_tick = pwm_tick + 1'b1;
            end else begin
                pwm_tick = '0;
                if (last_slot) begin
                    slot_pos = '0;
                    scan_r = '0;
                    scan_c = '0;
                end else begin
                    slot_pos = slot_pos + 1'b1;
                    if (int'(scan_c) + 1 < COLS) begin
                        scan_c = scan_c + 1'b1;
                    end else begin
                        scan_c = '0;
                        scan_r = scan_r + 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // Gap before the next item: usually of random length, with runs of no gaps at all.
    function automatic int next_gap(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic note_failure(string what, scan_line_t want, scan_line_t got);
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected rows %h cols %h pos %0d last %b,",
                      " got rows %h cols %h pos %0d last %b"},
                     $realtime, what, want.rows, want.cols, want.pos, want.last,
                     got.rows, got.cols, got.pos, got.last);
    endtask

    always @(posedge aclk) begin
        scan_line_t got;
        scan_line_t want;
        if (aresetn) begin
            // Results are checked before new expectations are queued at the same edge.
            if (m_tvalid && m_tready) begin
                got.rows = m_tdata[7:0];
                got.cols = m_tdata[15:8];
                got.pos  = m_tdata[21:16];
                got.last = m_tlast;
                if (got.last)
                    frame_count++;
                if (expected_lines.size() == 0) begin
                    note_failure("result with nothing expected", '0, got);
                end else begin
                    want = expected_lines.pop_front();
                    checked_count++;
                    if (got.rows !== want.rows || got.cols !== want.cols ||
                        got.pos !== want.pos || got.last !== want.last)
                        note_failure("line mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_lines(opcode_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
                expected_lines.push_back(cur_typed ? cur_want : want);
                if (opcode_t'(s_tuser) == OP_TICK)
                    tick_items++;
                else
                    write_items++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, expected_lines.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        forever begin
            stall = next_gap(sink_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(opcode_t op, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val,
                             logic typed, scan_line_t want, bit drain);
        int gap;
        gap = next_gap(src_calm);
        if (gap > 0 || drain) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // Hold the input side off until every outstanding result is back.
            if (drain) begin
                do @(posedge aclk); while (expected_lines.size() != 0);
            end
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {val, idx};
        s_tuser   <= op;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(int tick_pct, bit drain);
        opcode_t op;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < tick_pct)
            op = OP_TICK;
        else if (pick < tick_pct + (100 - tick_pct) * 4 / 10)
            op = OP_WRITE_LED;
        else if (pick < tick_pct + (100 - tick_pct) / 2)
            op = OP_WRITE_ALL;
        else
            op = OP_WRITE_CURVE;
        idx = $urandom_range(0, 255);
        // Writes to one LED stay mostly in range; the rest use any index and so also probe the ignored ones.
        if (op == OP_WRITE_LED && $urandom_range(0, 3) != 0)
            idx = $urandom_range(0, NUM_LEDS - 1);
        if ($urandom_range(0, 7) == 0)
            val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
            val = $urandom_range(0, 255);
        send_item(op, idx, val, 1'b0, '0, drain);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].want, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_random(45, i == RANDOM_ITEMS / 2);

        s_tvalid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d tick items and %0d store writes, %0d results checked.",
                 tick_items, write_items, checked_count);
        $display("The scan wrapped at frame end %0d times; %0d failures recorded.",
                 frame_count, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
